// ----- rtl/msc_pkg.sv -----
`timescale 1ns / 1ps

package msc_pkg;

	// Sensor table size and address width
	localparam int SENSORS   = 32;
	localparam int SENSOR_AW = (SENSORS > 1) ? $clog2(SENSORS) : 1;

	// Field widths
	localparam int IDX_W    = 5;
	localparam int READ_W   = 12;
	localparam int PCT_W    = 7;
	localparam int THR_W    = 7;
	localparam int STREAK_W = 8;
	localparam int COUNT_W  = 6;
	localparam int CFG_W    = 12;
	localparam int ENTRY_W  = STREAK_W + 1;

	// Divider sizing: both quotients stay below 2**QUO_W
	localparam int QUO_W    = 7;
	localparam int QCNT_W   = $clog2(QUO_W);
	localparam int DIVD_W   = READ_W + PCT_W;

	localparam logic [READ_W-1:0]   VALID_LOW  = 12'd100;
	localparam logic [READ_W-1:0]   VALID_HIGH = 12'd4000;
	localparam logic [READ_W-1:0]   TOTAL_MAX  = 12'd4095;
	localparam logic [COUNT_W-1:0]  COUNT_MAX  = 6'd63;
	localparam logic [STREAK_W-1:0] STREAK_MAX = 8'd255;
	localparam logic [PCT_W-1:0]    PCT_FULL   = 7'd100;

	// Register reset values
	localparam logic [READ_W-1:0]   AIR_RST    = 12'd3000;
	localparam logic [READ_W-1:0]   WATER_RST  = 12'd1200;
	localparam logic [THR_W-1:0]    THR_RST    = 7'd30;
	localparam logic [STREAK_W-1:0] LIMIT_RST  = 8'd6;

	typedef enum logic [1:0] {
		CFG_AIR       = 2'd0,
		CFG_WATER     = 2'd1,
		CFG_THRESHOLD = 2'd2,
		CFG_LIMIT     = 2'd3
	} msc_cfg_idx_t;

	typedef struct packed {
		logic [IDX_W-1:0]  sensor_index;
		logic [READ_W-1:0] reading;
		logic              last_in_scan;
	} msc_in_t;

	typedef struct packed {
		logic [IDX_W-1:0]    sensor_id;
		logic [PCT_W-1:0]    percent;
		logic                reading_valid;
		logic [STREAK_W-1:0] dry_streak;
		logic                dry_alert;
		logic                scan_done;
		logic [PCT_W-1:0]    average_percent;
		logic [COUNT_W-1:0]  valid_sensors;
	} msc_out_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic map_start;
		logic update;
		logic avg_start;
		logic out_load;
	} msc_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_done;
		logic last;
		logic out_busy;
	} msc_status_t;

endpackage

// ----- rtl/msc_ram.sv -----
`timescale 1ns / 1ps

module msc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/msc_div.sv -----
`timescale 1ns / 1ps

module msc_div
	import msc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [READ_W-1:0] divisor,
	output logic              done,
	output logic [QUO_W-1:0]  quotient
);

	logic              busy_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [DIVD_W-1:0] rem_q;
	logic [READ_W-1:0] dvs_q;
	logic [QUO_W-1:0]  quo_q;
	logic [DIVD_W-1:0] trial;
	logic              fits;

	// one quotient bit per cycle, most significant first
	assign trial    = DIVD_W'(dvs_q) << cnt_q;
	assign fits     = rem_q >= trial;
	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= QCNT_W'(QUO_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - trial;
			end
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

endmodule

// ----- rtl/msc_dp.sv -----
`timescale 1ns / 1ps

module msc_dp
	import msc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  msc_cmd_t          cmd,
	output msc_status_t       status,
	input  msc_in_t           item,
	output logic              result_valid,
	input  logic              result_stall,
	output msc_out_t          result,
	input  logic              cfg_we,
	input  msc_cfg_idx_t      cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	// configuration
	logic [READ_W-1:0]   air_q;
	logic [READ_W-1:0]   water_q;
	logic [THR_W-1:0]    thr_q;
	logic [STREAK_W-1:0] lim_q;

	// captured item
	logic [IDX_W-1:0]  idx_q;
	logic [READ_W-1:0] raw_q;
	logic              last_q;

	// per-item results
	logic [PCT_W-1:0]    pct_q;
	logic [STREAK_W-1:0] streak_q;
	logic                alert_q;

	// scan sums
	logic [READ_W-1:0]  total_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_snap_q;

	// sensor table
	logic [SENSORS-1:0]   ent_vld_q;
	logic                 rd_vld_s1;
	logic [SENSOR_AW-1:0] rd_addr;
	logic [SENSOR_AW-1:0] wr_addr;
	logic [ENTRY_W-1:0]   rd_data;
	logic [ENTRY_W-1:0]   wr_data;
	logic                 wr_en;

	// divider
	logic              div_start;
	logic [DIVD_W-1:0] div_dividend;
	logic [READ_W-1:0] div_divisor;
	logic              div_done;
	logic [QUO_W-1:0]  div_quo;

	logic                  in_range;
	logic                  reading_ok;
	logic [READ_W-1:0]     span_num;
	logic [PCT_W-1:0]      pct_now;
	logic [STREAK_W-1:0]   old_streak;
	logic                  old_sent;
	logic [STREAK_W-1:0]   new_streak;
	logic                  new_sent;
	logic [STREAK_W-1:0]   lim_eff;
	logic                  alert_now;
	logic [READ_W:0]       sum_wide;
	logic                  result_valid_q;
	msc_out_t              result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			air_q   <= AIR_RST;
			water_q <= WATER_RST;
			thr_q   <= THR_RST;
			lim_q   <= LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_AIR:       air_q   <= cfg_data;
				CFG_WATER:     water_q <= cfg_data;
				CFG_THRESHOLD: thr_q   <= cfg_data[THR_W-1:0];
				CFG_LIMIT:     lim_q   <= cfg_data[STREAK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q  <= item.sensor_index;
			raw_q  <= item.reading;
			last_q <= item.last_in_scan;
		end
	end

	assign in_range   = 7'(idx_q) < 7'(SENSORS);
	assign reading_ok = (raw_q > VALID_LOW) && (raw_q < VALID_HIGH);

	// map: clamp at the calibration points, divide in between
	assign span_num     = air_q - raw_q;
	assign div_start    = cmd.map_start || cmd.avg_start;
	assign div_dividend = cmd.avg_start ? DIVD_W'(total_q)
	                                    : DIVD_W'(span_num) * DIVD_W'(PCT_FULL);
	assign div_divisor  = cmd.avg_start ? READ_W'(count_q) : (air_q - water_q);

	msc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		if (raw_q >= air_q) begin
			pct_now = '0;
		end else if (raw_q <= water_q) begin
			pct_now = PCT_FULL;
		end else begin
			pct_now = div_quo;
		end
	end

	// sensor table: entry is {sent, streak}, an unwritten entry reads as zero
	assign rd_addr = SENSOR_AW'(item.sensor_index);
	assign wr_addr = SENSOR_AW'(idx_q);
	assign wr_en   = cmd.update && in_range;
	assign wr_data = {new_sent, new_streak};

	msc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SENSORS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (cmd.capture),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				ent_vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.capture) begin
				rd_vld_s1 <= ent_vld_q[rd_addr];
			end
		end
	end

	assign old_streak = rd_vld_s1 ? rd_data[STREAK_W-1:0] : '0;
	assign old_sent   = rd_vld_s1 && rd_data[STREAK_W];
	assign lim_eff    = (lim_q == '0) ? STREAK_W'(1) : lim_q;

	always_comb begin
		new_streak = old_streak;
		new_sent   = old_sent;
		if (reading_ok) begin
			if (pct_now < thr_q) begin
				if (old_streak != STREAK_MAX) begin
					new_streak = old_streak + 1'b1;
				end
			end else begin
				new_streak = '0;
				new_sent   = 1'b0;
			end
		end
		alert_now = (new_streak >= lim_eff) && !new_sent;
		if (alert_now) begin
			new_sent = 1'b1;
		end
	end

	assign sum_wide = {1'b0, total_q} + (READ_W + 1)'(pct_now);

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			pct_q    <= pct_now;
			streak_q <= in_range ? new_streak : '0;
			alert_q  <= in_range && alert_now;
		end
		if (cmd.avg_start) begin
			count_snap_q <= count_q;
		end
	end

	// running sums, both saturating on their own
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			count_q <= '0;
		end else if (cmd.avg_start) begin
			total_q <= '0;
			count_q <= '0;
		end else if (cmd.update && reading_ok) begin
			total_q <= sum_wide[READ_W] ? TOTAL_MAX : sum_wide[READ_W-1:0];
			if (count_q != COUNT_MAX) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q.sensor_id       <= idx_q;
			result_q.percent         <= pct_q;
			result_q.reading_valid   <= reading_ok;
			result_q.dry_streak      <= streak_q;
			result_q.dry_alert       <= alert_q;
			result_q.scan_done       <= last_q;
			result_q.average_percent <= (last_q && (count_snap_q != '0)) ? div_quo : '0;
			result_q.valid_sensors   <= last_q ? count_snap_q : '0;
		end
	end

	assign result_valid    = result_valid_q;
	assign result          = result_q;
	assign status.div_done = div_done;
	assign status.last     = last_q;
	assign status.out_busy = result_valid_q && result_stall;

endmodule

// ----- rtl/msc_ctrl.sv -----
`timescale 1ns / 1ps

module msc_ctrl
	import msc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  msc_status_t status,
	output msc_cmd_t    cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_LOAD   = 6'b000010,
		S_MAP    = 6'b000100,
		S_UPDATE = 6'b001000,
		S_AVG_GO = 6'b010000,
		S_AVG    = 6'b100000
	} msc_state_t;

	msc_state_t state_q;
	msc_state_t state_nxt;
	logic       finish_q;

	assign item_stall = (state_q != S_IDLE) || finish_q;

	always_comb begin
		state_nxt     = state_q;
		cmd           = '0;
		case (state_q)
			S_IDLE: begin
				if (item_valid && !finish_q) begin
					cmd.capture = 1'b1;
					state_nxt   = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.map_start = 1'b1;
				state_nxt     = S_MAP;
			end
			S_MAP: begin
				if (status.div_done) begin
					state_nxt = S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_nxt  = status.last ? S_AVG_GO : S_IDLE;
			end
			S_AVG_GO: begin
				cmd.avg_start = 1'b1;
				state_nxt     = S_AVG;
			end
			S_AVG: begin
				if (status.div_done) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
		// hand the finished transaction to the output register once it is free
		if (finish_q && !status.out_busy) begin
			cmd.out_load = 1'b1;
		end
	end

	// finish_q: a result is complete and waits for the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			finish_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				finish_q <= 1'b0;
			end else if ((state_q == S_UPDATE && !status.last)
			             || (state_q == S_AVG && status.div_done)) begin
				finish_q <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/moisture_scan_conditioner.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_stall     msc_in_t  (sensor_index, reading, last_in_scan)
// result    out        result_valid / result_stall msc_out_t (one result per item)
// config    in         cfg_we                      cfg_index, cfg_data (no read-back)
//
// An ordinary item runs capture, map and update before the next acceptance;
// the last item of a scan also runs the average. Both use the shared 7-step
// restoring divider, which runs once for the percentage map and once more for
// the scan average. Reset clears the controller, the running sums and the valid
// bits of the sensor table; no clearing pass is needed. A stalled result holds
// in the output register while the next item is already worked on; the block stalls
// its input while an item is in progress or a result waits for the output register.

module moisture_scan_conditioner
	import msc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  msc_in_t           item,
	output logic              result_valid,
	input  logic              result_stall,
	output msc_out_t          result,
	input  logic              cfg_we,
	input  msc_cfg_idx_t      cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	msc_cmd_t    cmd;
	msc_status_t status;

	// sequence the transaction: capture, map, update, optional average, hand off
	msc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	// hold configuration, sensor table, sums, divider and output register
	msc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

endmodule

// ----- rtl/msc_chk.sv -----
`timescale 1ns / 1ps

module msc_chk
	import msc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input msc_in_t           item,
	input logic              result_valid,
	input logic              result_stall,
	input msc_out_t          result,
	input logic              cfg_we,
	input msc_cfg_idx_t      cfg_index,
	input logic [CFG_W-1:0]  cfg_data
);

	// a stalled result transaction holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// one item at a time: an accepted item stalls the input next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input accepted twice in a row");

	// scan fields are zero outside the last item of a scan
	a_scan_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.scan_done |->
			result.average_percent == '0 && result.valid_sensors == '0)
		else $error("scan summary on a non-final item");

	// percentages stay in range
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.percent <= PCT_FULL && result.average_percent <= PCT_FULL)
		else $error("percentage out of range");

	// an alert needs a streak of at least one
	a_alert_streak: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.dry_alert |-> result.dry_streak != '0)
		else $error("alert with empty streak");

endmodule

bind moisture_scan_conditioner msc_chk u_msc_chk (.*);
